>>> rtl/cptg_pkg.sv
package cptg_pkg;

  // Package-wide sizes; the tone table is built here at elaboration.
  localparam int PHASE_BITS_DEF = 32;
  localparam int TIMER_BITS_DEF = 16;
  localparam int SIDX_BITS      = 10;
  localparam int QUARTER        = 1 << (SIDX_BITS - 2);
  localparam int QIDX_BITS      = SIDX_BITS - 2;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int STEP_W         = 32;
  localparam int MS_W           = 16;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Opcodes of an input item.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STEP_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAD_EN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ON_TIME  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_TIME = 3'd4;

  localparam logic [7:0] DAC_MID = 8'd128;

  typedef struct packed {
    logic [1:0] opcode;
    logic       ms_tick;
  } in_item_t;

  typedef struct packed {
    logic [7:0] dac_value;
    logic       tone_on;
  } out_item_t;

  typedef struct packed {
    logic [STEP_W-1:0] phase_step_a;
    logic [STEP_W-1:0] phase_step_b;
    logic              cadence_enable;
    logic [MS_W-1:0]   on_time_ms;
    logic [MS_W-1:0]   off_time_ms;
  } cfg_regs_t;

  // Work handed from the sequencing stage to the mixing stage.
  typedef struct packed {
    logic                 play;
    logic                 tone_on;
    logic [SIDX_BITS-1:0] idx_a;
    logic [SIDX_BITS-1:0] idx_b;
  } mix_item_t;

  typedef logic [QUARTER-1:0][14:0] qsine_tab_t;

  // Sine of r quarters-of-a-table over the first quadrant, scaled to 32767.
  function automatic logic [14:0] quarter_sine(input logic [63:0] r);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    x    = (r * HALF_PI_Q30) >> (SIDX_BITS - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = (($unsigned(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

  function automatic qsine_tab_t build_qsine();
    qsine_tab_t t;
    for (int i = 0; i < QUARTER; i++) begin
      t[i] = quarter_sine(64'(i));
    end
    return t;
  endfunction

  localparam qsine_tab_t  QSINE      = build_qsine();
  localparam logic [14:0] QSINE_PEAK = quarter_sine(64'(QUARTER));

  // Full-turn lookup by quadrant symmetry.
  function automatic logic signed [15:0] sine_lookup(input logic [SIDX_BITS-1:0] idx);
    logic [1:0]           q;
    logic [QIDX_BITS-1:0] r;
    logic [14:0]          mag;
    q = idx[SIDX_BITS-1 -: 2];
    r = idx[QIDX_BITS-1:0];
    if (q[0]) begin
      mag = (r == '0) ? QSINE_PEAK : QSINE[QIDX_BITS'(-r)];
    end else begin
      mag = QSINE[r];
    end
    return q[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

>>> rtl/cptg_cfg.sv
module cptg_cfg
  import cptg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_regs_t             regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_STEP_A:   regs_nxt.phase_step_a   = wr_data[STEP_W-1:0];
        REG_STEP_B:   regs_nxt.phase_step_b   = wr_data[STEP_W-1:0];
        REG_CAD_EN:   regs_nxt.cadence_enable = wr_data[0];
        REG_ON_TIME:  regs_nxt.on_time_ms     = wr_data[MS_W-1:0];
        REG_OFF_TIME: regs_nxt.off_time_ms    = wr_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

>>> rtl/cptg_seq.sv
module cptg_seq
  import cptg_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t regs,
  input  logic      in_valid,
  input  in_item_t  in_item,
  output logic      in_stall,
  input  logic      mix_free,
  output logic      mix_valid,
  output mix_item_t mix_item
);

  localparam int EXT_W = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;
  localparam int CMP_W = (TIMER_BITS > MS_W) ? TIMER_BITS : MS_W;

  logic [PHASE_BITS-1:0] phase_a_r, phase_a_nxt;
  logic [PHASE_BITS-1:0] phase_b_r, phase_b_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic                  sounding_r, sounding_nxt;
  logic                  running_r, running_nxt;
  logic                  valid_r, valid_nxt;
  mix_item_t             item_r, item_nxt;

  logic [EXT_W-1:0]      step_a_ext, step_b_ext;
  logic [TIMER_BITS-1:0] elapsed_inc;
  logic                  free, accept, play;

  assign step_a_ext = EXT_W'(regs.phase_step_a);
  assign step_b_ext = EXT_W'(regs.phase_step_b);

  assign free     = !valid_r || mix_free;
  assign accept   = in_valid && free;
  assign in_stall = !free;

  assign elapsed_inc = (in_item.ms_tick && (elapsed_r != '1)) ? elapsed_r + 1'b1 : elapsed_r;

  always_comb begin
    phase_a_nxt  = phase_a_r;
    phase_b_nxt  = phase_b_r;
    elapsed_nxt  = elapsed_r;
    sounding_nxt = sounding_r;
    running_nxt  = running_r;
    play         = 1'b0;
    case (in_item.opcode)
      OP_START: begin
        running_nxt  = 1'b1;
        sounding_nxt = 1'b1;
        phase_a_nxt  = '0;
        phase_b_nxt  = '0;
        elapsed_nxt  = '0;
      end
      OP_STOP: begin
        running_nxt  = 1'b0;
        sounding_nxt = 1'b0;
      end
      OP_TICK: begin
        if (running_r) begin
          if (regs.cadence_enable) begin
            elapsed_nxt = elapsed_inc;
            if (sounding_r && (CMP_W'(elapsed_inc) >= CMP_W'(regs.on_time_ms))) begin
              sounding_nxt = 1'b0;
              elapsed_nxt  = '0;
            end else if (!sounding_r &&
                         (CMP_W'(elapsed_inc) >= CMP_W'(regs.off_time_ms))) begin
              sounding_nxt = 1'b1;
              elapsed_nxt  = '0;
            end
          end else begin
            sounding_nxt = 1'b1;
            elapsed_nxt  = '0;
          end
        end
        if (sounding_nxt) begin
          play        = 1'b1;
          phase_a_nxt = phase_a_r + step_a_ext[PHASE_BITS-1:0];
          phase_b_nxt = phase_b_r + step_b_ext[PHASE_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    item_nxt         = item_r;
    valid_nxt        = mix_free ? 1'b0 : valid_r;
    if (accept) begin
      valid_nxt        = 1'b1;
      item_nxt.play    = play;
      item_nxt.tone_on = sounding_nxt;
      // The table is addressed by the phases as they stood before this tick.
      item_nxt.idx_a   = phase_a_r[PHASE_BITS-1 -: SIDX_BITS];
      item_nxt.idx_b   = phase_b_r[PHASE_BITS-1 -: SIDX_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_a_r  <= '0;
      phase_b_r  <= '0;
      elapsed_r  <= '0;
      sounding_r <= 1'b0;
      running_r  <= 1'b0;
      valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        phase_a_r  <= phase_a_nxt;
        phase_b_r  <= phase_b_nxt;
        elapsed_r  <= elapsed_nxt;
        sounding_r <= sounding_nxt;
        running_r  <= running_nxt;
      end
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign mix_valid = valid_r;
  assign mix_item  = item_r;

endmodule

>>> rtl/cptg_mix.sv
module cptg_mix
  import cptg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      mix_valid,
  input  mix_item_t mix_item,
  output logic      mix_free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;
  logic signed [15:0] sa, sb;
  logic signed [17:0] sum_s;
  logic [16:0]        sum_u;
  logic [24:0]        prod;

  assign mix_free = !out_valid_r || !out_stall;

  assign sa    = sine_lookup(mix_item.idx_a);
  assign sb    = sine_lookup(mix_item.idx_b);
  assign sum_s = 18'(sa) + 18'(sb) + 18'sd65536;
  // The offset sum is never negative, so its low 17 bits are the value.
  assign sum_u = sum_s[16:0];
  assign prod  = {sum_u, 8'd0} - 25'(sum_u);

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (mix_free) begin
      out_valid_nxt     = mix_valid;
      out_nxt.dac_value = mix_item.play ? prod[24:17] : DAC_MID;
      out_nxt.tone_on   = mix_item.tone_on;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> rtl/call_progress_tone_generator.sv
// Channel   Direction  Handshake                 Payload
// in_       input      in_valid / in_stall       in_item   (opcode, ms_tick)
// out_      output     out_valid / out_stall     out_item  (dac_value, tone_on)
// cfg_      input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item is taken every cycle while in_stall is low; its result passes through
// the sequencing register and then the mixing output register before it is
// offered on out_valid.
// Synchronous reset clears configuration, phases, cadence and all valids.
// A stall on the result side holds the output register and backs up through
// the sequencing register to in_stall; configuration writes are always taken.
module call_progress_tone_generator
  import cptg_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_regs_t regs;
  mix_item_t mix_item;
  logic      mix_valid;
  logic      mix_free;

  assign cfg_ready = 1'b1;

  cptg_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (regs)
  );

  cptg_seq #(
    .PHASE_BITS (PHASE_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .regs      (regs),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .mix_free  (mix_free),
    .mix_valid (mix_valid),
    .mix_item  (mix_item)
  );

  cptg_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .mix_valid (mix_valid),
    .mix_item  (mix_item),
    .mix_free  (mix_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
